// ===== rtl/ltok_pkg.sv =====
// Shared types, constants and character-class functions of the lambda expression tokenizer.
package ltok_pkg;

  localparam int unsigned ChW   = 8;
  localparam int unsigned LenW  = 6;
  localparam int unsigned PosW  = 32;
  localparam int unsigned KindW = 3;

  localparam logic [LenW-1:0] MAX_TOKEN = LenW'(32);
  localparam logic [LenW-1:0] KW_LEN    = LenW'(6);
  localparam int unsigned     RES_DEPTH = 4;

  localparam logic [ChW-1:0] CH_END  = 8'h00;
  localparam logic [ChW-1:0] CH_PLUS = 8'h2B;
  localparam logic [ChW-1:0] CH_LPAR = 8'h28;
  localparam logic [ChW-1:0] CH_RPAR = 8'h29;

  typedef enum logic [KindW-1:0] {
    KIND_END      = 3'd0,
    KIND_ERROR    = 3'd1,
    KIND_PLUS     = 3'd2,
    KIND_LPAREN   = 3'd3,
    KIND_RPAREN   = 3'd4,
    KIND_NUMBER   = 3'd5,
    KIND_VARIABLE = 3'd6,
    KIND_LAMBDA   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_VAR  = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e           kind;
    logic [LenW-1:0] length;
    logic [PosW-1:0] start;
    logic [ChW-1:0]  symbol;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [ChW-1:0] kw_char(input logic [2:0] idx);
    logic [ChW-1:0] c;
    case (idx)
      3'd0: c = 8'h6C;
      3'd1: c = 8'h61;
      3'd2: c = 8'h6D;
      3'd3: c = 8'h62;
      3'd4: c = 8'h64;
      3'd5: c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [ChW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [ChW-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [ChW-1:0] c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
  endfunction

  function automatic res_t run_res(input mode_e mode, input logic km,
                                   input logic [LenW-1:0] len,
                                   input logic [PosW-1:0] start);
    res_t r;
    r = '0;
    if (mode == MODE_NUM) begin
      r.kind = KIND_NUMBER;
    end else if (km && (len == KW_LEN)) begin
      r.kind = KIND_LAMBDA;
    end else begin
      r.kind = KIND_VARIABLE;
    end
    r.length = len;
    r.start  = start;
    return r;
  endfunction

endpackage

// ===== rtl/ltok_if.sv =====
// Valid/ready channel interfaces for input bytes and result words.
interface ltok_in_if import ltok_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface ltok_out_if import ltok_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [LenW-1:0]  length;
  logic [PosW-1:0]  start_res;
  logic [ChW-1:0]   symbol;
  logic             last;

  modport source (output valid, output kind, output length, output start_res,
                  output symbol, output last, input ready);
  modport sink (input valid, input kind, input length, input start_res,
                input symbol, input last, output ready);
endinterface

// ===== rtl/ltok_scan.sv =====
// Input byte register, scanner state and per-byte token classification.
module ltok_scan import ltok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltok_in_if.sink    in_i,
  input  logic       room_i,
  output push_t      push_o
);

  logic            in_valid_q, in_valid_d;
  logic [ChW-1:0]  ch_q;
  mode_e           mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic            km_q, km_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic            accept, fire;
  logic            run_act, cont, km_next;
  logic [LenW-1:0] len_inc;
  logic            has_a, has_b;
  res_t            res_a, res_b;

  assign fire       = in_valid_q && room_i;
  assign in_i.ready = !in_valid_q || room_i;
  assign accept     = in_i.valid && in_i.ready;
  assign in_valid_d = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_comb begin
    mode_d  = mode_q;
    len_d   = len_q;
    km_d    = km_q;
    start_d = start_q;
    pos_d   = pos_q + PosW'(1);
    has_a   = 1'b0;
    has_b   = 1'b0;
    res_a   = '0;
    res_b   = '0;
    run_act = (mode_q == MODE_NUM) || (mode_q == MODE_VAR);
    cont    = ((mode_q == MODE_NUM) && is_digit(ch_q)) ||
              ((mode_q == MODE_VAR) && is_letter(ch_q));
    km_next = km_q && (len_q < KW_LEN) && (ch_q == kw_char(len_q[2:0]));
    len_inc = len_q + LenW'(1);

    if (cont) begin
      km_d  = km_next;
      len_d = len_inc;
      if (len_inc >= MAX_TOKEN) begin
        has_a  = 1'b1;
        res_a  = run_res(mode_q, km_next, len_inc, start_q);
        mode_d = MODE_IDLE;
        len_d  = '0;
        km_d   = 1'b0;
      end
    end else begin
      if (run_act) begin
        has_a = 1'b1;
        res_a = run_res(mode_q, km_q, len_q, start_q);
      end
      mode_d = MODE_IDLE;
      len_d  = '0;
      km_d   = 1'b0;
      res_b.start = pos_q;
      if (ch_q == CH_END) begin
        has_b      = 1'b1;
        res_b.kind = KIND_END;
      end else if (is_space(ch_q)) begin
        has_b = 1'b0;
      end else if (ch_q == CH_PLUS || ch_q == CH_LPAR || ch_q == CH_RPAR) begin
        has_b        = 1'b1;
        res_b.length = LenW'(1);
        res_b.symbol = ch_q;
        if (ch_q == CH_PLUS) begin
          res_b.kind = KIND_PLUS;
        end else if (ch_q == CH_LPAR) begin
          res_b.kind = KIND_LPAREN;
        end else begin
          res_b.kind = KIND_RPAREN;
        end
      end else if (is_digit(ch_q)) begin
        mode_d  = MODE_NUM;
        len_d   = LenW'(1);
        start_d = pos_q;
      end else if (is_letter(ch_q)) begin
        mode_d  = MODE_VAR;
        len_d   = LenW'(1);
        km_d    = (ch_q == kw_char(3'd0));
        start_d = pos_q;
      end else begin
        has_b        = 1'b1;
        res_b.kind   = KIND_ERROR;
        res_b.length = LenW'(1);
        res_b.symbol = ch_q;
      end
    end

    if (ch_q == CH_END) begin
      mode_d  = MODE_IDLE;
      len_d   = '0;
      km_d    = 1'b0;
      start_d = '0;
      pos_d   = '0;
    end
  end

  always_comb begin
    push_o.cnt     = fire ? ({1'b0, has_a} + {1'b0, has_b}) : 2'd0;
    push_o.r0      = has_a ? res_a : res_b;
    push_o.r0.last = !(has_a && has_b);
    push_o.r1      = res_b;
    push_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      len_q      <= '0;
      km_q       <= 1'b0;
      start_q    <= '0;
      pos_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (fire) begin
        mode_q  <= mode_d;
        len_q   <= len_d;
        km_q    <= km_d;
        start_q <= start_d;
        pos_q   <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= in_i.ch;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ch_q == CH_END) |=> (pos_q == '0 && mode_q == MODE_IDLE && len_q == '0))
    else $error("end of stream did not clear the scanner state");

  a_pair_starts_with_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |-> (push_o.r0.kind == KIND_NUMBER ||
      push_o.r0.kind == KIND_VARIABLE || push_o.r0.kind == KIND_LAMBDA))
    else $error("two results from one byte without a pending run first");

  a_idle_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (len_q == '0 && !km_q))
    else $error("idle scanner holds a run length");
`endif

endmodule

// ===== rtl/ltok_fifo.sv =====
// Result queue that takes up to two result words per cycle and hands out one.
module ltok_fifo import ltok_pkg::*; #(
  parameter int unsigned Depth = RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  push_t       push_i,
  output logic        room_o,
  ltok_out_if.source  res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, wptr_inc, wptr_inc2, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW:0]   avail;
  logic            pop;
  res_t            head;

  assign pop       = res_o.valid && res_o.ready;
  assign avail     = (CntW + 1)'(Depth) - {1'b0, count_q} + (CntW + 1)'(pop);
  assign room_o    = avail >= (CntW + 1)'(2);
  assign wptr_inc  = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
  assign wptr_inc2 = (wptr_inc == PtrLast) ? '0 : wptr_inc + PtrW'(1);

  always_comb begin
    case (push_i.cnt)
      2'd1:    wptr_d = wptr_inc;
      2'd2:    wptr_d = wptr_inc2;
      default: wptr_d = wptr_q;
    endcase
    rptr_d  = pop ? ((rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1)) : rptr_q;
    count_d = count_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_inc] <= push_i.r1;
    end
  end

  assign head            = mem_q[rptr_q];
  assign res_o.valid     = count_q != '0;
  assign res_o.kind      = head.kind;
  assign res_o.length    = head.length;
  assign res_o.start_res = head.start;
  assign res_o.symbol    = head.symbol;
  assign res_o.last      = head.last;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count exceeds its depth");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("result pushed without room in the queue");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("queue count did not drop after a lone read");
`endif

endmodule

// ===== rtl/lambda_expr_tokenizer_core.sv =====
// Top level of the streaming tokenizer for lambda expressions.
// One input byte is taken per clock and produces zero, one or two result words
// (kind, length, start position, symbol and a last flag on the final word of
// that byte). The byte passes an input register and one stage of classification
// logic, which writes its results into a result queue of ResDepth words at
// once, so the block sustains one byte per cycle while the result side
// keeps up. A byte that ends a pending run and is itself a token writes both of
// its words in the same cycle; the input stalls only while the queue has fewer
// than two free words, counting the word read in that cycle. The result words
// are registered in the queue before they reach the output. A zero byte ends the
// stream, emits the end word and restarts positions at zero.
module lambda_expr_tokenizer_core import ltok_pkg::*; #(
  parameter int unsigned ResDepth = RES_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltok_in_if.sink    in_i,
  ltok_out_if.source res_o
);

  push_t push;
  logic  room;

  ltok_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  ltok_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule

// ===== verif/ltok_token_checker.sv =====
`timescale 1ns / 1ps
// Token checker: predicts tokenizer result words from accepted bytes and compares them.
module ltok_token_checker import ltok_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltok_in_if          in_w,
  ltok_out_if         res_w,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam logic [47:0] KwText = "lambda";
  localparam int unsigned PrintCap = 40;

  mode_e           scan_mode;
  logic [LenW-1:0] run_len;
  logic            kw_ok;
  logic [PosW-1:0] run_start;
  logic [PosW-1:0] next_pos;
  res_t            token_q[$];
  int unsigned     fails = 0;

  assign fail_cnt_o = fails;

  function automatic logic [ChW-1:0] kw_at(input int unsigned idx);
    return KwText[8*(5-idx) +: 8];
  endfunction

  function automatic logic digit_byte(input logic [ChW-1:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic letter_byte(input logic [ChW-1:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic blank_byte(input logic [ChW-1:0] c);
    return c inside {[8'h09:8'h0D], 8'h20};
  endfunction

  function automatic res_t make_token(input kind_e kind, input logic [LenW-1:0] len,
                                      input logic [PosW-1:0] pos, input logic [ChW-1:0] sym);
    res_t r;
    r.kind   = kind;
    r.length = len;
    r.start  = pos;
    r.symbol = sym;
    r.last   = 1'b0;
    return r;
  endfunction

  // Closes the pending run and returns its token.
  function automatic res_t close_run();
    kind_e k;
    if (scan_mode == MODE_NUM) begin
      k = KIND_NUMBER;
    end else if (kw_ok && run_len == KW_LEN) begin
      k = KIND_LAMBDA;
    end else begin
      k = KIND_VARIABLE;
    end
    scan_mode = MODE_IDLE;
    kw_ok     = 1'b0;
    close_run = make_token(k, run_len, run_start, '0);
    run_len   = '0;
  endfunction

  task automatic predict_tokens(input logic [ChW-1:0] c);
    res_t            found[$];
    res_t            r;
    logic [PosW-1:0] pos;
    logic            absorbed;
    pos      = next_pos;
    absorbed = 1'b0;
    if ((scan_mode == MODE_NUM && digit_byte(c)) || (scan_mode == MODE_VAR && letter_byte(c))) begin
      if (!(kw_ok && run_len < KW_LEN && c == kw_at(run_len))) kw_ok = 1'b0;
      run_len = run_len + 1'b1;
      if (run_len >= MAX_TOKEN) found.push_back(close_run());
      absorbed = 1'b1;
    end else if (scan_mode == MODE_NUM || scan_mode == MODE_VAR) begin
      found.push_back(close_run());
    end else begin
      scan_mode = MODE_IDLE;
    end

    if (!absorbed) begin
      if (c == CH_END) begin
        found.push_back(make_token(KIND_END, '0, pos, '0));
      end else if (blank_byte(c)) begin
      end else if (c == CH_PLUS) begin
        found.push_back(make_token(KIND_PLUS, LenW'(1), pos, c));
      end else if (c == CH_LPAR) begin
        found.push_back(make_token(KIND_LPAREN, LenW'(1), pos, c));
      end else if (c == CH_RPAR) begin
        found.push_back(make_token(KIND_RPAREN, LenW'(1), pos, c));
      end else if (digit_byte(c)) begin
        scan_mode = MODE_NUM;
        run_len   = LenW'(1);
        kw_ok     = 1'b0;
        run_start = pos;
      end else if (letter_byte(c)) begin
        scan_mode = MODE_VAR;
        run_len   = LenW'(1);
        kw_ok     = (c == kw_at(0));
        run_start = pos;
      end else begin
        found.push_back(make_token(KIND_ERROR, LenW'(1), pos, c));
      end
    end

    if (c == CH_END) begin
      scan_mode = MODE_IDLE;
      run_len   = '0;
      kw_ok     = 1'b0;
      run_start = '0;
      next_pos  = '0;
    end else begin
      next_pos = pos + 1'b1;
    end

    if (found.size() != 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) token_q.push_back(found[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [PosW-1:0] got,
                                 input logic [PosW-1:0] want);
    if (fails < PrintCap) begin
      $display("%0t ltok_token_checker: %s got %0h want %0h", $time, what, got, want);
    end
    fails++;
  endtask

  task automatic check_word();
    res_t want;
    if (token_q.size() == 0) begin
      report_mismatch("word with nothing expected, kind", PosW'(res_w.kind), '0);
    end else begin
      want = token_q.pop_front();
      if (res_w.kind !== want.kind) report_mismatch("kind", PosW'(res_w.kind), PosW'(want.kind));
      if (res_w.length !== want.length) begin
        report_mismatch("length", PosW'(res_w.length), PosW'(want.length));
      end
      if (res_w.start_res !== want.start) report_mismatch("start", res_w.start_res, want.start);
      if (res_w.symbol !== want.symbol) begin
        report_mismatch("symbol", PosW'(res_w.symbol), PosW'(want.symbol));
      end
      if (res_w.last !== want.last) report_mismatch("last", PosW'(res_w.last), PosW'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode = MODE_IDLE;
      run_len   = '0;
      kw_ok     = 1'b0;
      run_start = '0;
      next_pos  = '0;
      token_q.delete();
      pending_o <= 0;
    end else begin
      if (in_w.valid && in_w.ready) predict_tokens(in_w.ch);
      if (res_w.valid && res_w.ready) check_word();
      pending_o <= token_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives random token streams into the tokenizer and gives the verdict.
module tb_top import ltok_pkg::*; ();

  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned ByteTarget  = 1250;
  localparam int unsigned CalmFrom    = 1050;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          calm = 1'b0;
  bit          gap_on = 1'b1;

  ltok_in_if  in_w ();
  ltok_out_if res_w ();

  lambda_expr_tokenizer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .res_o  (res_w)
  );

  ltok_token_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_w       (in_w),
    .res_w      (res_w),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LimitCycles) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // The result side stalls in short bursts, with calm stretches in between.
  initial begin
    int unsigned hold;
    bit          noisy;
    res_w.ready = 1'b0;
    hold        = 0;
    noisy       = 1'b1;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) noisy = !noisy;
      if (hold != 0) begin
        hold--;
        res_w.ready <= 1'b0;
      end else if (!calm && noisy && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 3);
        res_w.ready <= 1'b0;
      end else begin
        res_w.ready <= 1'b1;
      end
    end
  end

  function automatic logic [ChW-1:0] pick_letter();
    return $urandom_range(0, 1) ? ChW'(8'h61 + $urandom_range(0, 25)) :
                                  ChW'(8'h41 + $urandom_range(0, 25));
  endfunction

  function automatic logic [ChW-1:0] pick_digit();
    return ChW'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [ChW-1:0] pick_blank();
    int unsigned r;
    r = $urandom_range(9, 14);
    return (r == 14) ? ChW'(8'h20) : ChW'(r);
  endfunction

  task automatic send_byte(input logic [ChW-1:0] c);
    if (!calm && gap_on && $urandom_range(0, 5) == 0) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_w.valid <= 1'b1;
    in_w.ch    <= c;
    do @(posedge clk_i); while (!in_w.ready);
    sent++;
    calm = (sent >= CalmFrom);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // One lexical piece: keyword, near miss of the keyword, word, number,
  // a run of 28 to 70 bytes, punctuation or a raw byte.
  task automatic send_piece();
    string       kw;
    int unsigned n;
    kw = "lambda";
    case ($urandom_range(0, 10))
      0, 1: send_text(kw);
      2: begin
        n = $urandom_range(1, 6);
        for (int unsigned i = 0; i < n; i++) send_byte(kw[i]);
        send_byte($urandom_range(0, 3) == 0 ? pick_digit() : pick_letter());
      end
      3, 4: begin
        n = $urandom_range(1, 8);
        for (int unsigned i = 0; i < n; i++) send_byte(pick_letter());
      end
      5, 6: begin
        n = $urandom_range(1, 6);
        for (int unsigned i = 0; i < n; i++) send_byte(pick_digit());
      end
      7: begin
        n = $urandom_range(28, 70);
        if ($urandom_range(0, 1)) begin
          for (int unsigned i = 0; i < n; i++) send_byte(pick_letter());
        end else begin
          for (int unsigned i = 0; i < n; i++) send_byte(pick_digit());
        end
      end
      8, 9: begin
        case ($urandom_range(0, 2))
          0: send_byte(CH_PLUS);
          1: send_byte(CH_LPAR);
          default: send_byte(CH_RPAR);
        endcase
      end
      default: send_byte(ChW'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_phrase();
    int unsigned count;
    gap_on = ($urandom_range(0, 3) != 0);
    count  = $urandom_range(1, 12);
    for (int unsigned i = 0; i < count; i++) begin
      send_piece();
      if ($urandom_range(0, 2) != 0) send_byte(pick_blank());
    end
    if ($urandom_range(0, 1) == 0) send_byte(CH_END);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_w.valid = 1'b0;
    in_w.ch    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A keyword, punctuation, a number ended by punctuation, blanks,
    // high error bytes, a word ended by a digit and a run ended by end of stream.
    send_text("lambda(x+12)");
    send_byte(8'h09);
    send_byte(8'h0D);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("Zq7");
    send_byte(CH_END);

    while (sent < ByteTarget) send_phrase();
    in_w.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
